// ===== src/rmsal_pkg.sv =====
// Shared types, constants and constant tables of the RMS audio leveler.
// Used by rms_audio_leveler_top; depends on nothing else.
package rmsal_pkg;

    localparam int WINDOW_DEPTH = 131072;
    localparam int CHANNELS     = 2;
    localparam int HALF_DEPTH   = WINDOW_DEPTH / 2;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W       = $clog2(CHANNELS * WINDOW_DEPTH);
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DCLIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = 3'd6;

    // Register reset values.
    localparam logic [6:0]  RST_TARGET = 7'h6C;        // -20
    localparam logic [7:0]  RST_FLOOR  = 8'hD8;        // -40
    localparam logic [23:0] RST_STEP   = 24'd244424;
    localparam logic [19:0] RST_INTV   = 20'd15984;
    localparam logic [22:0] RST_DCLIM  = 23'd41943;
    localparam logic [22:0] RST_KNEE   = 23'd5938679;
    localparam logic [22:0] RST_CEIL   = 23'd7476473;

    // Gain format is unsigned Q4.20.
    localparam logic [23:0] ONE_Q20  = 24'h100000;
    localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } t_out;

    // Integer square root, evaluated only on constants.
    function automatic logic [63:0] f_isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > x) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q.30 value of 2^(2^-k), each one the root of the one before.
    function automatic logic [31:0] f_root(input int k);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int i = 0; i < 16; i++) begin
            if (i < k) root = f_isqrt64(root << 30);
        end
        return root[31:0];
    endfunction

    localparam logic [31:0] ROOTS [16] = '{
        f_root(1),  f_root(2),  f_root(3),  f_root(4),
        f_root(5),  f_root(6),  f_root(7),  f_root(8),
        f_root(9),  f_root(10), f_root(11), f_root(12),
        f_root(13), f_root(14), f_root(15), f_root(16)
    };

endpackage

// ===== src/rms_audio_leveler_top.sv =====
// Top level of the stereo RMS leveler with soft limiter.
// Depends on rmsal_pkg for types, constants and the root-of-two table.
// The time from an accepted beat to its result grows per channel with knee compression and
// with a gain update; it is set by the 64-step shared divider and the one-bit-a-cycle log
// normalizer. A new beat is taken in the cycle after the result is registered; o_stall stays
// high until then, so the next beat waits for the last one, longer while the sink stalls a
// waiting result.
// Reset is synchronous and active low; unwritten window entries read as zero
// through the fill count, so no clearing pass runs after reset.
module rms_audio_leveler_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  rmsal_pkg::t_in                    i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output rmsal_pkg::t_out                   o_data,
    input  logic                              i_cfg_we,
    input  logic [rmsal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rmsal_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rmsal_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIV   = 5'd1;
    localparam logic [4:0] S_X2    = 5'd2;
    localparam logic [4:0] S_P     = 5'd3;
    localparam logic [4:0] S_RDOLD = 5'd4;
    localparam logic [4:0] S_SUMS  = 5'd5;
    localparam logic [4:0] S_SQ2   = 5'd6;
    localparam logic [4:0] S_DC    = 5'd7;
    localparam logic [4:0] S_BL1   = 5'd8;
    localparam logic [4:0] S_BL2   = 5'd9;
    localparam logic [4:0] S_MAG   = 5'd10;
    localparam logic [4:0] S_KNEE  = 5'd11;
    localparam logic [4:0] S_LNORM = 5'd12;
    localparam logic [4:0] S_LSQ   = 5'd13;
    localparam logic [4:0] S_K1    = 5'd14;
    localparam logic [4:0] S_K2    = 5'd15;
    localparam logic [4:0] S_K3    = 5'd16;
    localparam logic [4:0] S_CLAMP = 5'd17;
    localparam logic [4:0] S_LV0   = 5'd18;
    localparam logic [4:0] S_LV1   = 5'd19;
    localparam logic [4:0] S_GU    = 5'd20;
    localparam logic [4:0] S_POW   = 5'd21;
    localparam logic [4:0] S_PSH   = 5'd22;
    localparam logic [4:0] S_G2    = 5'd23;
    localparam logic [4:0] S_CAP   = 5'd24;
    localparam logic [4:0] S_NEXT  = 5'd25;
    localparam logic [4:0] S_FIN   = 5'd26;

    localparam logic [21:0] LOG_LIM   = 22'(46 << 16);
    localparam logic [31:0] LOG_Q23   = 32'(23 << 16);
    localparam logic [24:0] T_MAX     = 25'(24 << 16);
    localparam logic [24:0] T_OFS     = 25'(20 << 16);
    localparam logic [21:0] THREE_ONE = 22'(3 << 20);

    // Control and configuration.
    logic [4:0]  r_state;
    logic [4:0]  r_ret;
    logic [6:0]  r_target;
    logic [7:0]  r_floor;
    logic [23:0] r_step;
    logic [19:0] r_intv;
    logic [22:0] r_dclim;
    logic [22:0] r_knee;
    logic [22:0] r_ceil;

    // Block state.
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_fill_old;
    logic [IDX_W-1:0]   r_widx;
    logic [19:0]        r_ipos;
    logic [19:0]        r_iv;
    logic [CH_W-1:0]    r_ch;
    logic signed [41:0] r_sum [CHANNELS];
    logic [63:0]        r_sq  [CHANNELS];
    logic [23:0]        r_ug  [CHANNELS];
    logic [23:0]        r_upg [CHANNELS];
    logic [23:0]        r_ag  [CHANNELS];
    logic [23:0]        r_apg [CHANNELS];
    logic signed [15:0] r_lvl [CHANNELS];

    // Working registers.
    logic signed [23:0] r_in_s [CHANNELS];
    logic [23:0]        r_res  [CHANNELS];
    logic [20:0]        r_x;
    logic [20:0]        r_x2;
    logic [20:0]        r_p;
    logic signed [23:0] r_old;
    logic signed [23:0] r_play;
    logic [24:0]        r_dmag;
    logic               r_neg;
    logic [63:0]        r_acc;
    logic [24:0]        r_g;
    logic [31:0]        r_m;
    logic [63:0]        r_prod;
    logic [63:0]        r_dq;
    logic [19:0]        r_drem;
    logic [19:0]        r_dd;
    logic [5:0]         r_dcnt;
    logic [63:0]        r_ly;
    logic [5:0]         r_le;
    logic [31:0]        r_lm;
    logic [21:0]        r_lr;
    logic [3:0]         r_lcnt;
    logic signed [15:0] r_lev;
    logic [4:0]         r_tip;
    logic [15:0]        r_tfrac;
    logic [3:0]         r_pk;
    logic [23:0]        r_gnew;
    logic               r_ovalid;
    t_out               r_out;

    // Window memory.
    logic [23:0]       mem [CHANNELS * WINDOW_DEPTH];
    logic [23:0]       r_rdata;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Shared multiplier.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // Combinational helpers.
    logic [19:0]        iv_eff;
    logic [19:0]        pos_cl;
    logic [IDX_W:0]     play_sum;
    logic [IDX_W-1:0]   play_idx;
    logic [ADDR_W-1:0]  ch_base;
    logic               old_ok;
    logic               play_ok;
    logic signed [23:0] cur_s;
    logic signed [23:0] old_v;
    logic [23:0]        s_abs;
    logic [23:0]        old_abs;
    logic [41:0]        sum_abs;
    logic [20:0]        rem_sh;
    logic               div_hit;
    logic [21:0]        three_m_2x;
    logic [20:0]        one_m_p;
    logic [23:0]        dc_q;
    logic signed [25:0] dc_s;
    logic signed [25:0] diff;
    logic [23:0]        fac;
    logic [31:0]        lval;
    logic [32:0]        lsq;
    logic [15:0]        lbit;
    logic [21:0]        lv_d;
    logic [40:0]        lv_r;
    logic [16:0]        lv_mag;
    logic signed [15:0] floor256;
    logic signed [17:0] edb;
    logic [16:0]        emag;
    logic signed [24:0] tval;
    logic [4:0]         psh;
    logic [31:0]        pgain;
    logic [23:0]        g2;
    logic [24:0]        cap_sum;
    logic [23:0]        cap;
    logic [23:0]        mclamp;
    logic [20:0]        ipos_inc;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Index arithmetic and window validity from the fill count.
    always_comb begin
        iv_eff   = (r_intv == 20'd0) ? 20'd1 : r_intv;
        pos_cl   = (r_ipos > iv_eff) ? iv_eff : r_ipos;
        play_sum = {1'b0, r_widx} + (IDX_W+1)'(HALF_DEPTH);
        play_idx = (play_sum >= (IDX_W+1)'(WINDOW_DEPTH))
                 ? IDX_W'(play_sum - (IDX_W+1)'(WINDOW_DEPTH)) : play_sum[IDX_W-1:0];
        ch_base  = ADDR_W'(r_ch) * ADDR_W'(WINDOW_DEPTH);
        old_ok   = (FILL_W'(r_widx) < r_fill_old);
        play_ok  = (FILL_W'(play_idx) < r_fill_old);
        cur_s    = r_in_s[r_ch];
        old_v    = old_ok ? $signed(r_rdata) : 24'sd0;
        s_abs    = cur_s[23] ? 24'(-cur_s) : 24'(cur_s);
        old_abs  = r_old[23] ? 24'(-r_old) : 24'(r_old);
        sum_abs  = r_sum[r_ch][41] ? 42'(-r_sum[r_ch]) : 42'(r_sum[r_ch]);
        ipos_inc = {1'b0, r_ipos} + 21'd1;
    end

    // Divider step: one quotient bit per cycle.
    always_comb begin
        rem_sh  = {r_drem, r_dq[63]};
        div_hit = (rem_sh >= {1'b0, r_dd});
    end

    // Datapath terms of the individual steps.
    always_comb begin
        three_m_2x = THREE_ONE - {r_x, 1'b0};
        one_m_p    = 21'(ONE_Q20) - r_p;
        dc_q       = r_dq[23:0];
        if (dc_q >= {1'b0, r_dclim}) begin
            dc_s = r_sum[r_ch][41] ? -$signed({2'b00, dc_q}) : $signed({2'b00, dc_q});
        end else begin
            dc_s = 26'sd0;
        end
        diff     = 26'(r_play) - dc_s;
        fac      = 24'h800000 - {1'b0, r_knee};
        lval     = {10'b0, r_lr} - LOG_Q23;
        lsq      = mul_p[63:31];
        lbit     = 16'd1 << (4'd15 - r_lcnt);
        lv_d     = (r_lr >= LOG_LIM) ? 22'd0 : (LOG_LIM - r_lr);
        lv_r     = mul_p[40:0] + 41'h800000;
        lv_mag   = (lv_r[40:24] > 17'd32768) ? 17'd32768 : lv_r[40:24];
        floor256 = $signed({r_floor, 8'b0});
        edb      = $signed({{3{r_target[6]}}, r_target, 8'b0}) - 18'(r_lev);
        emag     = edb[17] ? 17'(-edb) : 17'(edb);
        tval     = (edb[17] ? -$signed({2'b00, mul_p[30:8]})
                            : $signed({2'b00, mul_p[30:8]})) + $signed(T_OFS);
        psh      = 5'd30 - r_tip;
        pgain    = r_acc[31:0] >> psh;
        g2       = (r_gnew == 24'd0) ? ONE_Q20 : r_gnew;
        cap_sum  = {1'b0, r_ug[r_ch]} + {1'b0, r_step};
        cap      = cap_sum[24] ? GAIN_MAX : cap_sum[23:0];
        mclamp   = (r_m > {9'b0, r_ceil}) ? {1'b0, r_ceil} : r_m[23:0];
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_X2: begin
                mul_a = {11'b0, r_dq[20:0]};
                mul_b = {11'b0, r_dq[20:0]};
            end
            S_P: begin
                mul_a = {11'b0, r_x2};
                mul_b = {10'b0, three_m_2x};
            end
            S_SUMS: begin
                mul_a = {8'b0, s_abs};
                mul_b = {8'b0, s_abs};
            end
            S_SQ2: begin
                mul_a = {8'b0, old_abs};
                mul_b = {8'b0, old_abs};
            end
            S_BL1: begin
                mul_a = {11'b0, r_p};
                mul_b = {8'b0, r_ag[r_ch]};
            end
            S_BL2: begin
                mul_a = {11'b0, one_m_p};
                mul_b = {8'b0, r_apg[r_ch]};
            end
            S_MAG: begin
                mul_a = {7'b0, r_dmag};
                mul_b = {7'b0, r_g};
            end
            S_LSQ: begin
                mul_a = r_lm;
                mul_b = r_lm;
            end
            S_K1: begin
                mul_a = {8'b0, fac};
                mul_b = lval;
            end
            S_K2: begin
                mul_a = r_prod[31:0];
                mul_b = 32'd19728;
            end
            S_K3: begin
                mul_a = r_prod[63:32];
                mul_b = 32'd19728;
            end
            S_LV1: begin
                mul_a = {10'b0, lv_d};
                mul_b = 32'd197283;
            end
            S_GU: begin
                mul_a = {15'b0, emag};
                mul_b = 32'd10885;
            end
            S_POW: begin
                mul_a = r_acc[31:0];
                mul_b = ROOTS[r_pk];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Memory port control.
    always_comb begin
        mem_we  = (r_state == S_SUMS);
        mem_re  = (r_state == S_RDOLD) || (r_state == S_SUMS);
        wr_addr = ch_base + ADDR_W'(r_widx);
        rd_addr = (r_state == S_SUMS) ? ch_base + ADDR_W'(play_idx)
                                      : ch_base + ADDR_W'(r_widx);
    end

    // Window memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_addr] <= cur_s;
        if (mem_re) r_rdata <= mem[rd_addr];
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_target <= RST_TARGET;
            r_floor  <= RST_FLOOR;
            r_step   <= RST_STEP;
            r_intv   <= RST_INTV;
            r_dclim  <= RST_DCLIM;
            r_knee   <= RST_KNEE;
            r_ceil   <= RST_CEIL;
            r_fill   <= '0;
            r_widx   <= '0;
            r_ipos   <= '0;
            r_ch     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
                r_sq[c]  <= '0;
                r_ug[c]  <= ONE_Q20;
                r_upg[c] <= ONE_Q20;
                r_ag[c]  <= '0;
                r_apg[c] <= '0;
                r_lvl[c] <= '0;
            end
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET: r_target <= i_cfg_data[6:0];
                    CFG_FLOOR:  r_floor  <= i_cfg_data[7:0];
                    CFG_STEP:   r_step   <= i_cfg_data[23:0];
                    CFG_INTV:   r_intv   <= i_cfg_data[19:0];
                    CFG_DCLIM:  r_dclim  <= i_cfg_data[22:0];
                    CFG_KNEE:   r_knee   <= i_cfg_data[22:0];
                    CFG_CEIL:   r_ceil   <= i_cfg_data[22:0];
                    default: ;
                endcase
            end

            // The output register fills in the last step and empties when the sink
            // takes the beat.
            if ((r_state == S_FIN) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in_s[0]             <= i_data.left_sample;
                        r_in_s[CHANNELS-1]    <= (CHANNELS > 1) ? i_data.right_sample
                                                                : i_data.left_sample;
                        r_iv       <= iv_eff;
                        r_fill_old <= r_fill;
                        if (r_fill < FILL_W'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                        r_ch   <= '0;
                        r_dq   <= 64'(pos_cl) << 20;
                        r_dd   <= iv_eff;
                        r_drem <= '0;
                        r_dcnt <= '0;
                        r_ret  <= S_X2;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dq   <= {r_dq[62:0], div_hit};
                    r_drem <= div_hit ? 20'(rem_sh - {1'b0, r_dd}) : rem_sh[19:0];
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd63) r_state <= r_ret;
                end
                S_X2: begin
                    r_x     <= r_dq[20:0];
                    r_x2    <= mul_p[40:20];
                    r_state <= S_P;
                end
                S_P: begin
                    r_p     <= mul_p[40:20];
                    r_state <= S_RDOLD;
                end
                S_RDOLD: begin
                    r_state <= S_SUMS;
                end
                S_SUMS: begin
                    r_old       <= old_v;
                    r_sum[r_ch] <= r_sum[r_ch] + 42'(cur_s) - 42'(old_v);
                    r_sq[r_ch]  <= r_sq[r_ch] + mul_p;
                    r_state     <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq[r_ch] <= r_sq[r_ch] - mul_p;
                    r_play     <= play_ok ? $signed(r_rdata) : 24'sd0;
                    r_dq       <= 64'(sum_abs);
                    r_dd       <= 20'(r_fill);
                    r_drem     <= '0;
                    r_dcnt     <= '0;
                    r_ret      <= S_DC;
                    r_state    <= S_DIV;
                end
                S_DC: begin
                    r_dmag  <= diff[25] ? 25'(-diff) : 25'(diff);
                    r_neg   <= diff[25];
                    r_state <= S_BL1;
                end
                S_BL1: begin
                    r_acc   <= mul_p;
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_g     <= 25'((r_acc + mul_p) >> 20);
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_m     <= mul_p[51:20];
                    r_state <= S_KNEE;
                end
                S_KNEE: begin
                    if (r_m > {9'b0, r_knee}) begin
                        r_ly    <= 64'(r_m - {9'b0, r_knee} + 32'h800000);
                        r_le    <= 6'd63;
                        r_ret   <= S_K1;
                        r_state <= S_LNORM;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                // Log2 unit: normalize one bit a cycle, then 16 squarings.
                S_LNORM: begin
                    if (r_ly[63] || (r_le == 6'd0)) begin
                        r_lm    <= r_ly[63:32];
                        r_lr    <= {r_le, 16'b0};
                        r_lcnt  <= '0;
                        r_state <= S_LSQ;
                    end else begin
                        r_ly <= r_ly << 1;
                        r_le <= r_le - 1'b1;
                    end
                end
                S_LSQ: begin
                    if (lsq[32]) begin
                        r_lr <= r_lr | {6'b0, lbit};
                        r_lm <= lsq[32:1];
                    end else begin
                        r_lm <= lsq[31:0];
                    end
                    r_lcnt <= r_lcnt + 1'b1;
                    if (r_lcnt == 4'd15) r_state <= r_ret;
                end
                // Knee compression: knee + fac * L * 19728 / 2^32.
                S_K1: begin
                    r_prod  <= mul_p;
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_acc   <= mul_p;
                    r_state <= S_K3;
                end
                S_K3: begin
                    r_m     <= {9'b0, r_knee} + mul_p[31:0] + r_acc[63:32];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_res[r_ch] <= r_neg ? 24'(-mclamp) : mclamp;
                    if (r_ipos == 20'd0) begin
                        r_dq    <= r_sq[r_ch];
                        r_dd    <= 20'(r_fill);
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_ret   <= S_LV0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                // Window level in Q8.8 dB from the mean square.
                S_LV0: begin
                    if (r_dq == 64'd0) begin
                        r_lev   <= 16'sh8000;
                        r_state <= S_GU;
                    end else begin
                        r_ly    <= r_dq;
                        r_le    <= 6'd63;
                        r_ret   <= S_LV1;
                        r_state <= S_LNORM;
                    end
                end
                S_LV1: begin
                    r_lev   <= $signed(16'(-lv_mag));
                    r_state <= S_GU;
                end
                // New gain from the level error.
                S_GU: begin
                    if (r_lev < floor256) begin
                        r_gnew  <= r_ug[r_ch];
                        r_state <= S_CAP;
                    end else if (tval >= $signed(T_MAX)) begin
                        r_gnew  <= GAIN_MAX;
                        r_state <= S_G2;
                    end else if (tval < 25'sd0) begin
                        r_gnew  <= '0;
                        r_state <= S_G2;
                    end else begin
                        r_tip   <= tval[20:16];
                        r_tfrac <= tval[15:0];
                        r_acc   <= 64'h4000_0000;
                        r_pk    <= '0;
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_tfrac[4'd15 - r_pk]) r_acc <= 64'(mul_p[63:30]);
                    r_pk <= r_pk + 1'b1;
                    if (r_pk == 4'd15) r_state <= S_PSH;
                end
                S_PSH: begin
                    r_gnew  <= pgain[23:0];
                    r_state <= S_G2;
                end
                S_G2: begin
                    // A rising gain is held while the level does not rise.
                    if ((g2 > ONE_Q20) && (r_lev <= r_lvl[r_ch])) begin
                        r_gnew <= r_ug[r_ch];
                    end else begin
                        r_gnew <= g2;
                    end
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_upg[r_ch] <= r_ug[r_ch];
                    r_ug[r_ch]  <= (r_gnew > cap) ? cap : r_gnew;
                    r_lvl[r_ch] <= r_lev;
                    r_state     <= S_NEXT;
                end
                S_NEXT: begin
                    r_ag[r_ch]  <= r_ug[r_ch];
                    r_apg[r_ch] <= r_upg[r_ch];
                    if (r_ch == CH_W'(CHANNELS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_RDOLD;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.left_out  <= r_res[0];
                        r_out.right_out <= (CHANNELS > 1) ? r_res[CHANNELS-1] : 24'd0;
                        r_widx   <= (r_widx == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                         : r_widx + 1'b1;
                        r_ipos   <= (ipos_inc >= {1'b0, r_iv}) ? 20'd0 : ipos_inc[19:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
